// ===== sv/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the min-heap queue
// Entry layout, operation and status codes, and the back-end state type.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_W      = 16;
    localparam int HANDLE_W   = 8;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 9;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_INSERT,
        K_EXTRACT,
        K_PEEK,
        K_NOP
    } t_kind;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        t_kind  kind;
        t_entry ent;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_PEEK_GOT,
        S_EXT_ROOT,
        S_EXT_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } t_state;

endpackage

// ===== sv/bmhq_in_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_in_if: request channel of the min-heap queue
// Valid/ready channel carrying one operation with its entry.
// ----------------------------------------------------------------------------
interface bmhq_in_if;
    logic                          valid;
    logic                          ready;
    logic [bmhq_pkg::OP_W-1:0]     operation;
    logic [bmhq_pkg::KEY_W-1:0]    key;
    logic [bmhq_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, output operation, output key, output handle,
                    input ready);
    modport sink   (input valid, input operation, input key, input handle,
                    output ready);
endinterface

// ===== sv/bmhq_out_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_out_if: result channel of the min-heap queue
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface bmhq_out_if;
    logic                           valid;
    logic                           ready;
    logic                           out_valid;
    logic [bmhq_pkg::KEY_W-1:0]     out_key;
    logic [bmhq_pkg::HANDLE_W-1:0]  out_handle;
    logic [bmhq_pkg::STATUS_W-1:0]  status;
    logic [bmhq_pkg::OUT_CNT_W-1:0] entry_count;

    modport source (output valid, output out_valid, output out_key,
                    output out_handle, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input out_valid, input out_key,
                    input out_handle, input status, input entry_count,
                    output ready);
endinterface

// ===== sv/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bmhq_front.sv =====
// ----------------------------------------------------------------------------
// bmhq_front: request intake and command queue
// Accepts request beats, decodes the operation and holds up to two commands.
// ----------------------------------------------------------------------------
module bmhq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bmhq_in_if.sink          i_req,
    output logic             o_cmd_valid,
    output bmhq_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_ready
);

    bmhq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    bmhq_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    always_comb begin
        w_cmd.ent.key    = i_req.key;
        w_cmd.ent.handle = i_req.handle;
        case (i_req.operation)
            bmhq_pkg::OP_INSERT:  w_cmd.kind = bmhq_pkg::K_INSERT;
            bmhq_pkg::OP_EXTRACT: w_cmd.kind = bmhq_pkg::K_EXTRACT;
            bmhq_pkg::OP_PEEK:    w_cmd.kind = bmhq_pkg::K_PEEK;
            default:              w_cmd.kind = bmhq_pkg::K_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== sv/bmhq_engine.sv =====
// ----------------------------------------------------------------------------
// bmhq_engine: heap sequencer
// Runs insert sift-up and extract sift-down over the entry RAM, level by
// level, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bmhq_engine #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  bmhq_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    bmhq_out_if.source     o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    bmhq_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_pos, n_pos;
    bmhq_pkg::t_entry r_mov, n_mov;
    bmhq_pkg::t_entry r_lft, n_lft;
    logic             r_has_r, n_has_r;

    logic             r_ovalid, n_ovalid;
    logic             r_oval, n_oval;
    bmhq_pkg::t_entry r_oent, n_oent;
    bmhq_pkg::t_status r_ostat, n_ostat;
    logic [CW-1:0]    r_ocnt, n_ocnt;

    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    bmhq_pkg::t_entry w_wdata, w_rdata;
    logic [IW-1:0]    w_lidx, w_ridx, w_cnt_x;
    bmhq_pkg::t_entry w_best;
    logic             w_best_l, w_best_r;

    bmhq_ram #(
        .WIDTH ($bits(bmhq_pkg::t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_lidx  = {1'b0, r_pos, 1'b1};
    assign w_ridx  = {1'b0, r_pos, 1'b0} + IW'(2);
    assign w_cnt_x = IW'(r_count);

    // pick the smaller child; left wins a tie, the moving entry wins ties too
    always_comb begin
        w_best_l = (r_lft.key < r_mov.key);
        w_best   = w_best_l ? r_lft : r_mov;
        w_best_r = r_has_r && (w_rdata.key < w_best.key);
        if (w_best_r) w_best = w_rdata;
    end

    assign o_cmd_ready = (r_state == bmhq_pkg::S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmhq_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_mov   <= n_mov;
        r_lft   <= n_lft;
        r_has_r <= n_has_r;
        r_oval  <= n_oval;
        r_oent  <= n_oent;
        r_ostat <= n_ostat;
        r_ocnt  <= n_ocnt;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_mov    = r_mov;
        n_lft    = r_lft;
        n_has_r  = r_has_r;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_oval   = r_oval;
        n_oent   = r_oent;
        n_ostat  = r_ostat;
        n_ocnt   = r_ocnt;
        w_we     = 1'b0;
        w_waddr  = r_pos;
        w_wdata  = r_mov;
        w_re     = 1'b0;
        w_raddr  = '0;

        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_oval  = 1'b0;
                    n_oent  = '0;
                    n_ostat = bmhq_pkg::STAT_OK;
                    n_ocnt  = r_count;
                    case (i_cmd.kind)
                        bmhq_pkg::K_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_ostat  = bmhq_pkg::STAT_OVERFLOW;
                                n_ovalid = 1'b1;
                            end else begin
                                n_pos   = AW'(r_count);
                                n_mov   = i_cmd.ent;
                                n_count = r_count + 1'b1;
                                n_state = bmhq_pkg::S_INS_RD;
                            end
                        end
                        bmhq_pkg::K_EXTRACT, bmhq_pkg::K_PEEK: begin
                            if (r_count == '0) begin
                                n_ostat  = bmhq_pkg::STAT_EMPTY;
                                n_ovalid = 1'b1;
                            end else begin
                                w_re    = 1'b1;
                                n_state = (i_cmd.kind == bmhq_pkg::K_PEEK) ?
                                          bmhq_pkg::S_PEEK_GOT : bmhq_pkg::S_EXT_ROOT;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            bmhq_pkg::S_PEEK_GOT: begin
                n_oval   = 1'b1;
                n_oent   = w_rdata;
                n_ovalid = 1'b1;
                n_state  = bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_INS_RD: begin
                if (r_pos == '0) begin
                    w_we     = 1'b1;
                    n_ocnt   = r_count;
                    n_ovalid = 1'b1;
                    n_state  = bmhq_pkg::S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = AW'((r_pos - 1'b1) >> 1);
                    n_state = bmhq_pkg::S_INS_CMP;
                end
            end
            bmhq_pkg::S_INS_CMP: begin
                w_we = 1'b1;
                if (w_rdata.key > r_mov.key) begin
                    // move the parent down into the hole
                    w_wdata = w_rdata;
                    n_pos   = AW'((r_pos - 1'b1) >> 1);
                    n_state = bmhq_pkg::S_INS_RD;
                end else begin
                    n_ocnt   = r_count;
                    n_ovalid = 1'b1;
                    n_state  = bmhq_pkg::S_IDLE;
                end
            end
            bmhq_pkg::S_EXT_ROOT: begin
                n_oval  = 1'b1;
                n_oent  = w_rdata;
                w_re    = 1'b1;
                w_raddr = AW'(r_count - 1'b1);
                n_state = bmhq_pkg::S_EXT_LAST;
            end
            bmhq_pkg::S_EXT_LAST: begin
                n_mov   = w_rdata;
                n_pos   = '0;
                n_count = r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    n_ocnt   = '0;
                    n_ovalid = 1'b1;
                    n_state  = bmhq_pkg::S_IDLE;
                end else begin
                    n_state = bmhq_pkg::S_DN_L;
                end
            end
            bmhq_pkg::S_DN_L: begin
                if (w_lidx >= w_cnt_x) begin
                    w_we     = 1'b1;
                    n_ocnt   = r_count;
                    n_ovalid = 1'b1;
                    n_state  = bmhq_pkg::S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_lidx[AW-1:0];
                    n_state = bmhq_pkg::S_DN_R;
                end
            end
            bmhq_pkg::S_DN_R: begin
                n_lft   = w_rdata;
                n_has_r = (w_ridx < w_cnt_x);
                w_re    = n_has_r;
                w_raddr = w_ridx[AW-1:0];
                n_state = bmhq_pkg::S_DN_CMP;
            end
            bmhq_pkg::S_DN_CMP: begin
                w_we = 1'b1;
                if (w_best_l || w_best_r) begin
                    // lift the smaller child into the hole
                    w_wdata = w_best;
                    n_pos   = w_best_r ? w_ridx[AW-1:0] : w_lidx[AW-1:0];
                    n_state = bmhq_pkg::S_DN_L;
                end else begin
                    n_ocnt   = r_count;
                    n_ovalid = 1'b1;
                    n_state  = bmhq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.out_valid   = r_oval;
    assign o_rsp.out_key     = r_oent.key;
    assign o_rsp.out_handle  = r_oent.handle;
    assign o_rsp.status      = r_ostat;
    assign o_rsp.entry_count = bmhq_pkg::OUT_CNT_W'(r_ocnt);

endmodule

// ===== sv/binary_min_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core: min-heap priority queue of (key, handle) entries
//
//   channel  dir  beat contents
//   i_req    in   operation, key, handle
//   o_rsp    out  out_valid, out_key, out_handle, status, entry_count
//
// A request passes through the command queue, then the heap sequencer: peek
// reads the root; insert reads each parent and moves it down while it is
// larger; extract reads the root and the last entry, then per level reads
// the children and lifts the smaller one, with one RAM read per step.
// Reset clears the entry count; the entry RAM needs no clearing pass.
// A two-deep command queue takes up to two requests while a result is stalled.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_in_if.sink    i_req,
    bmhq_out_if.source o_rsp
);

    logic           w_cmd_valid, w_cmd_ready;
    bmhq_pkg::t_cmd w_cmd;

    bmhq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    bmhq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== tb/binary_min_heap_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_tb: self-checking bench of the min-heap queue
// Drives insert, extract and peek requests with random gaps and stalls,
// tracks the heap in a behavioral copy and checks every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue_core_tb;

    localparam logic [bmhq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic                           hit;
        logic [bmhq_pkg::KEY_W-1:0]     key;
        logic [bmhq_pkg::HANDLE_W-1:0]  handle;
        logic [bmhq_pkg::STATUS_W-1:0]  status;
        logic [bmhq_pkg::OUT_CNT_W-1:0] count;
    } t_rsp;

    class heap_scoreboard;
        logic [bmhq_pkg::KEY_W-1:0]    keys[bmhq_pkg::CAPACITY];
        logic [bmhq_pkg::HANDLE_W-1:0] hdls[bmhq_pkg::CAPACITY];
        int                            fill;
        t_rsp                          pending[$];
        int                            errors;

        function void swap(int a, int b);
            logic [bmhq_pkg::KEY_W-1:0]    k;
            logic [bmhq_pkg::HANDLE_W-1:0] h;
            k = keys[a]; h = hdls[a];
            keys[a] = keys[b]; hdls[a] = hdls[b];
            keys[b] = k; hdls[b] = h;
        endfunction

        function void note_request(logic [bmhq_pkg::OP_W-1:0] op,
                                   logic [bmhq_pkg::KEY_W-1:0] key,
                                   logic [bmhq_pkg::HANDLE_W-1:0] hdl);
            t_rsp r;
            int   pos, up, lft, rgt, best;
            r = '{1'b0, '0, '0, bmhq_pkg::STAT_OK, '0};
            if (op == bmhq_pkg::OP_INSERT) begin
                if (fill >= bmhq_pkg::CAPACITY) begin
                    r.status = bmhq_pkg::STAT_OVERFLOW;
                end else begin
                    pos = fill;
                    keys[pos] = key; hdls[pos] = hdl;
                    fill++;
                    while (pos != 0) begin
                        up = (pos - 1) / 2;
                        if (keys[up] <= keys[pos]) break;
                        swap(pos, up);
                        pos = up;
                    end
                end
            end else if (op == bmhq_pkg::OP_EXTRACT || op == bmhq_pkg::OP_PEEK) begin
                if (fill == 0) begin
                    r.status = bmhq_pkg::STAT_EMPTY;
                end else begin
                    r.hit = 1'b1; r.key = keys[0]; r.handle = hdls[0];
                    if (op == bmhq_pkg::OP_EXTRACT) begin
                        fill--;
                        keys[0] = keys[fill]; hdls[0] = hdls[fill];
                        pos = 0;
                        forever begin
                            lft = 2 * pos + 1; rgt = 2 * pos + 2; best = pos;
                            if (lft < fill && keys[lft] < keys[best]) best = lft;
                            if (rgt < fill && keys[rgt] < keys[best]) best = rgt;
                            if (best == pos) break;
                            swap(pos, best);
                            pos = best;
                        end
                    end
                end
            end
            r.count = fill[bmhq_pkg::OUT_CNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            if (pending.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.hit !== exp.hit) begin
                $error("out_valid exp %0d got %0d", exp.hit, got.hit); errors++;
            end
            if (got.key !== exp.key) begin
                $error("out_key exp %0d got %0d", exp.key, got.key); errors++;
            end
            if (got.handle !== exp.handle) begin
                $error("out_handle exp %0d got %0d", exp.handle, got.handle); errors++;
            end
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status); errors++;
            end
            if (got.count !== exp.count) begin
                $error("entry_count exp %0d got %0d", exp.count, got.count); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bmhq_in_if  req_if();
    bmhq_out_if rsp_if();

    binary_min_heap_queue_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    heap_scoreboard sb;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        sb = new();
        req_if.valid = 1'b0;
        req_if.operation = bmhq_pkg::OP_INSERT;
        req_if.key = '0;
        req_if.handle = '0;
        rsp_if.ready = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
    end

    // sink side: random backpressure, check on each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result('{rsp_if.out_valid, rsp_if.out_key, rsp_if.out_handle,
                              rsp_if.status, rsp_if.entry_count});
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog: count cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_op(logic [bmhq_pkg::OP_W-1:0] op,
                           logic [bmhq_pkg::KEY_W-1:0] key,
                           logic [bmhq_pkg::HANDLE_W-1:0] hdl);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.handle    <= hdl;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, key, hdl);
    endtask

    task automatic random_op(int ins_pct);
        int r;
        logic [bmhq_pkg::OP_W-1:0] op;
        r = $urandom_range(99);
        if (r < ins_pct) op = bmhq_pkg::OP_INSERT;
        else if (r < ins_pct + (100 - ins_pct) * 3 / 4) op = bmhq_pkg::OP_EXTRACT;
        else if (r < 99) op = bmhq_pkg::OP_PEEK;
        else op = OP_UNUSED;
        // narrow keys give plenty of ties
        send_op(op,
                bmhq_pkg::KEY_W'($urandom_range(1) ? $urandom_range(7) : $urandom()),
                bmhq_pkg::HANDLE_W'($urandom()));
    endtask

    initial begin
        int n;
        stall_cycles = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 22; snk_idle_pct = 49;
        // empty heap, unused code, extreme fields, ties
        send_op(bmhq_pkg::OP_EXTRACT, 16'hFFFF, 8'hFF);
        send_op(bmhq_pkg::OP_PEEK, '0, '0);
        send_op(OP_UNUSED, 16'hFFFF, 8'hFF);
        send_op(bmhq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
        send_op(bmhq_pkg::OP_INSERT, 16'h0000, 8'h00);
        send_op(bmhq_pkg::OP_INSERT, 16'h0005, 8'hA5);
        send_op(bmhq_pkg::OP_INSERT, 16'h0005, 8'h5A);
        send_op(bmhq_pkg::OP_INSERT, 16'h0005, 8'h33);
        send_op(bmhq_pkg::OP_PEEK, '0, '0);
        send_op(OP_UNUSED, '0, '0);
        repeat (6) send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
        send_op(bmhq_pkg::OP_PEEK, '0, '0);

        for (n = 0; n < 130; n++) random_op(55);
        src_idle_pct = 49; snk_idle_pct = 22;
        // fill to capacity, then overflow
        for (n = 0; n < bmhq_pkg::CAPACITY + 4; n++)
            send_op(bmhq_pkg::OP_INSERT, bmhq_pkg::KEY_W'($urandom()),
                    bmhq_pkg::HANDLE_W'($urandom()));
        for (n = 0; n < 80; n++) random_op(45);
        src_idle_pct = 0; snk_idle_pct = 0;
        for (n = 0; n < 100; n++) random_op(40);
        for (n = 0; n < 10; n++) random_op(0);

        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
